FILE: sv/lapsh_pkg.sv
// Shared types and constants for the 3x3 Laplacian sharpening filter.
package lapsh_pkg;

    localparam int PIXEL_W          = 8;
    localparam int FRAME_WIDTH_W    = 11;
    localparam int FRAME_HEIGHT_W   = 16;
    localparam int CFG_DATA_W       = 16;
    localparam int CFG_INDEX_W      = 1;
    localparam int MAX_WIDTH_DEF    = 1024;
    localparam int QUEUE_DEPTH_DEF  = 4;

    localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = FRAME_WIDTH_W'(640);
    localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = FRAME_HEIGHT_W'(480);

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic emit;      // row above exists, one result at least
        logic inner;     // interior pixel, filter applies
        logic last_row;
        logic last_col;
    } pix_flags_t;

endpackage

FILE: sv/lapsh_ram.sv
// Generic simple dual-port RAM, read-first, registered read.
module lapsh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/lapsh_fifo.sv
// Small command queue between the front and back parts.
module lapsh_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             full,
    output logic             not_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: sv/lapsh_front.sv
// Front part: takes input pixels, tracks raster position, classifies each pixel.
module lapsh_front #(
    parameter int MAX_WIDTH = lapsh_pkg::MAX_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [lapsh_pkg::PIXEL_W-1:0]         pixel_in,
    input  logic [lapsh_pkg::FRAME_WIDTH_W-1:0]   frame_width,
    input  logic [lapsh_pkg::FRAME_HEIGHT_W-1:0]  frame_height,
    input  logic                                  queue_full,
    output logic                                  push,
    output logic [lapsh_pkg::PIXEL_W-1:0]         cmd_pix,
    output logic [$clog2(MAX_WIDTH)-1:0]          cmd_col,
    output lapsh_pkg::pix_flags_t                 cmd_flags
);

    import lapsh_pkg::*;

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int MWW = $clog2(MAX_WIDTH + 1);
    localparam int WW  = (MWW > FRAME_WIDTH_W) ? MWW : FRAME_WIDTH_W;
    localparam int HW  = FRAME_HEIGHT_W;

    logic [AW-1:0] col_reg, col_next;
    logic [HW-1:0] row_reg, row_next;

    logic [WW-1:0] fw_ext;
    logic [WW-1:0] eff_w;
    logic [WW-1:0] col_eff;
    logic [AW-1:0] col_a;
    logic [HW-1:0] eff_h;
    logic [HW-1:0] row_eff;
    logic          last_col;
    logic          last_row;

    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

    always_comb
    begin
        fw_ext = WW'(frame_width);
        if (fw_ext < WW'(3))
        begin
            eff_w = WW'(3);
        end
        else if (fw_ext > WW'(MAX_WIDTH))
        begin
            eff_w = WW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = fw_ext;
        end
        col_eff  = (WW'(col_reg) >= eff_w) ? eff_w - 1'b1 : WW'(col_reg);
        col_a    = col_eff[AW-1:0];
        last_col = (col_eff == eff_w - 1'b1);

        eff_h    = (frame_height < HW'(3)) ? HW'(3) : frame_height;
        row_eff  = (row_reg >= eff_h) ? eff_h - 1'b1 : row_reg;
        last_row = (row_eff == eff_h - 1'b1);

        cmd_flags.emit     = (row_eff != '0);
        cmd_flags.inner    = (row_eff >= HW'(2)) && (col_eff != '0) && !last_col;
        cmd_flags.last_row = last_row;
        cmd_flags.last_col = last_col;
        cmd_pix            = pixel_in;
        cmd_col            = col_a;

        col_next = col_reg;
        row_next = row_reg;
        if (push)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_eff + 1'b1;
            end
            else
            begin
                col_next = col_a + 1'b1;
                row_next = row_eff;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

FILE: sv/lapsh_back.sv
// Back part: line stores, five-point kernel, saturation and output register.
module lapsh_back #(
    parameter int MAX_WIDTH = lapsh_pkg::MAX_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    output logic                            pop,
    input  logic [lapsh_pkg::PIXEL_W-1:0]   cmd_pix,
    input  logic [$clog2(MAX_WIDTH)-1:0]    cmd_col,
    input  lapsh_pkg::pix_flags_t           cmd_flags,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [lapsh_pkg::PIXEL_W-1:0]   pixel_out,
    output logic                            frame_end
);

    import lapsh_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    logic               s1_valid_reg, s1_valid_next;
    logic               s1_phase_reg, s1_phase_next;
    logic [PIXEL_W-1:0] s1_pix_reg;
    logic [AW-1:0]      s1_col_reg;
    pix_flags_t         s1_flags_reg;
    logic [PIXEL_W-1:0] window_centre_reg, window_centre_next;

    logic               out_valid_reg, out_valid_next;
    logic [PIXEL_W-1:0] pixel_out_reg, pixel_out_next;
    logic               frame_end_reg, frame_end_next;

    logic [PIXEL_W-1:0] centre;
    logic [PIXEL_W-1:0] right;
    logic [PIXEL_W-1:0] up;
    logic [AW-1:0]      right_addr;

    logic [10:0]        five_c;
    logic [9:0]         sum4;
    logic signed [11:0] diff;
    logic [PIXEL_W-1:0] result;

    logic out_free;
    logic load_out;
    logic s1_done;

    assign right_addr = cmd_col + 1'b1;

    lapsh_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) u_prev_c (
        .clk     (clk),
        .wr_en   (pop),
        .wr_addr (cmd_col),
        .wr_data (cmd_pix),
        .rd_en   (pop),
        .rd_addr (cmd_col),
        .rd_data (centre)
    );

    lapsh_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) u_prev_r (
        .clk     (clk),
        .wr_en   (pop),
        .wr_addr (cmd_col),
        .wr_data (cmd_pix),
        .rd_en   (pop),
        .rd_addr (right_addr),
        .rd_data (right)
    );

    lapsh_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) u_prev2 (
        .clk     (clk),
        .wr_en   (s1_done),
        .wr_addr (s1_col_reg),
        .wr_data (centre),
        .rd_en   (pop),
        .rd_addr (cmd_col),
        .rd_data (up)
    );

    always_comb
    begin
        five_c = {1'b0, centre, 2'b00} + 11'(centre);
        sum4   = 10'(up) + 10'(s1_pix_reg) + 10'(window_centre_reg) + 10'(right);
        diff   = $signed({1'b0, five_c}) - $signed({2'b00, sum4});
        if (diff < 0)
        begin
            result = '0;
        end
        else if (diff > 12'sd255)
        begin
            result = '1;
        end
        else
        begin
            result = diff[PIXEL_W-1:0];
        end
        if (!s1_flags_reg.inner)
        begin
            result = '0;
        end
    end

    always_comb
    begin
        out_free = !out_valid_reg || !out_stall;
        load_out = s1_valid_reg && s1_flags_reg.emit && out_free;
        s1_done  = s1_valid_reg && (!s1_flags_reg.emit ||
                   (out_free && (s1_phase_reg || !s1_flags_reg.last_row)));
        pop      = cmd_valid && (!s1_valid_reg || s1_done);

        s1_valid_next = s1_valid_reg;
        s1_phase_next = s1_phase_reg;
        if (pop)
        begin
            s1_valid_next = 1'b1;
            s1_phase_next = 1'b0;
        end
        else if (s1_done)
        begin
            s1_valid_next = 1'b0;
            s1_phase_next = 1'b0;
        end
        else if (load_out)
        begin
            s1_phase_next = 1'b1;
        end

        window_centre_next = s1_done ? centre : window_centre_reg;

        out_valid_next = out_valid_reg;
        pixel_out_next = pixel_out_reg;
        frame_end_next = frame_end_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            pixel_out_next = s1_phase_reg ? '0 : result;
            frame_end_next = s1_phase_reg && s1_flags_reg.last_col;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            s1_phase_reg      <= 1'b0;
            window_centre_reg <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg      <= s1_valid_next;
            s1_phase_reg      <= s1_phase_next;
            window_centre_reg <= window_centre_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_pix_reg   <= cmd_pix;
            s1_col_reg   <= cmd_col;
            s1_flags_reg <= cmd_flags;
        end
        pixel_out_reg <= pixel_out_next;
        frame_end_reg <= frame_end_next;
    end

    assign out_valid = out_valid_reg;
    assign pixel_out = pixel_out_reg;
    assign frame_end = frame_end_reg;

endmodule

FILE: sv/laplacian_sharpen_3x3_top.sv
// Top level of the streaming 3x3 five-point Laplacian sharpening filter.
// Path: queue, stage-1 register and output register lie between input and output.
// Throughput: 1 pixel per cycle unless stalled; a last-row pixel gives two outputs.
// First row of a frame produces no output; the back part drains it at 1 per cycle.
// Reset: position counters cleared, width 640, height 480; line stores not cleared.
module laplacian_sharpen_3x3_top #(
    parameter int MAX_WIDTH   = lapsh_pkg::MAX_WIDTH_DEF,
    parameter int QUEUE_DEPTH = lapsh_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [lapsh_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lapsh_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [lapsh_pkg::PIXEL_W-1:0]        pixel_in,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [lapsh_pkg::PIXEL_W-1:0]        pixel_out,
    output logic                                 frame_end
);

    import lapsh_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int QW = $bits(pix_flags_t) + AW + PIXEL_W;

    logic [FRAME_WIDTH_W-1:0]  frame_width_reg, frame_width_next;
    logic [FRAME_HEIGHT_W-1:0] frame_height_reg, frame_height_next;

    logic               push;
    logic [PIXEL_W-1:0] f_pix;
    logic [AW-1:0]      f_col;
    pix_flags_t         f_flags;

    logic               queue_full;
    logic               queue_not_empty;
    logic               pop;
    logic [QW-1:0]      head;
    logic [PIXEL_W-1:0] b_pix;
    logic [AW-1:0]      b_col;
    pix_flags_t         b_flags;

    always_comb
    begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_next  = cfg_data[FRAME_WIDTH_W-1:0];
                REG_FRAME_HEIGHT: frame_height_next = cfg_data[FRAME_HEIGHT_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end
        else
        begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
        end
    end

    lapsh_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel_in     (pixel_in),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .queue_full   (queue_full),
        .push         (push),
        .cmd_pix      (f_pix),
        .cmd_col      (f_col),
        .cmd_flags    (f_flags)
    );

    lapsh_fifo #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({f_flags, f_col, f_pix}),
        .pop       (pop),
        .head_data (head),
        .full      (queue_full),
        .not_empty (queue_not_empty)
    );

    assign {b_flags, b_col, b_pix} = head;

    lapsh_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (queue_not_empty),
        .pop       (pop),
        .cmd_pix   (b_pix),
        .cmd_col   (b_col),
        .cmd_flags (b_flags),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pixel_out (pixel_out),
        .frame_end (frame_end)
    );

endmodule
